// File: hdl/mnrd_pkg.sv
// Package with the types, codes and constants of the monotonic note run detector.
package mnrd_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int ID_BITS_DEFAULT       = 16;

  localparam int KIND_BITS   = 2;
  localparam int PITCH_BITS  = 7;
  localparam int FIELD_BITS  = 16;
  localparam int STEP_BITS   = 7;
  localparam int NOTES_BITS  = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;

  localparam logic [STEP_BITS-1:0]  MIN_STEP_RESET      = 7'd1;
  localparam logic [STEP_BITS-1:0]  MAX_STEP_RESET      = 7'd2;
  localparam logic [NOTES_BITS-1:0] MIN_RUN_NOTES_RESET = 8'd3;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_NOTE_ON = 2'd0,
    KIND_REST_ON = 2'd1,
    KIND_OTHER   = 2'd2,
    KIND_SPARE   = 2'd3
  } event_kind_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MIN_STEP      = 2'd0,
    CFG_MAX_STEP      = 2'd1,
    CFG_MIN_RUN_NOTES = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [STEP_BITS-1:0]  min_step;
    logic [STEP_BITS-1:0]  max_step;
    logic [NOTES_BITS-1:0] min_run_notes;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] start_position;
    logic [FIELD_BITS-1:0] first_note_id;
    logic [FIELD_BITS-1:0] run_length;
    logic                  is_up;
  } result_t;

endpackage

// File: hdl/mnrd_if.sv
// Channel interfaces for note events, run results and configuration writes.
interface mnrd_note_if import mnrd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [KIND_BITS-1:0]  event_kind;
  logic [PITCH_BITS-1:0] note_pitch;
  logic [FIELD_BITS-1:0] note_id;
  logic                  last;

  modport source (output valid, event_kind, note_pitch, note_id, last, input ready);
  modport sink (input valid, event_kind, note_pitch, note_id, last, output ready);
endinterface

interface mnrd_run_if import mnrd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] start_position;
  logic [FIELD_BITS-1:0] first_note_id;
  logic [FIELD_BITS-1:0] run_length;
  logic                  is_up;

  modport source (output valid, start_position, first_note_id, run_length, is_up,
                  input ready);
  modport sink (input valid, start_position, first_note_id, run_length, is_up,
                output ready);
endinterface

interface mnrd_cfg_if import mnrd_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/monotonic_note_run_detector_unit.sv
// Top level of the monotonic note run detector: step logic and result queue.
// A run result enters the result queue when the transaction that closes it is accepted.
// Throughput: one note event per cycle while the queue is not full; the two-entry result
// queue lets input transactions continue while one result waits on the sink.
// Reset (synchronous, active high) clears the run state, the position count,
// the queue and restores the configuration registers to their defaults.
module monotonic_note_run_detector_unit import mnrd_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
  parameter int ID_BITS       = ID_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  mnrd_note_if.sink  note_in,
  mnrd_run_if.source run_out,
  mnrd_cfg_if.sink   cfg
);

  localparam logic [POSITION_BITS-1:0] POS_MAX   = {POSITION_BITS{1'b1}};
  localparam logic [FIELD_BITS-1:0]    STEPS_MAX = {FIELD_BITS{1'b1}};

  cfg_t cfg_values;

  mnrd_cfg_regs u_cfg_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cfg_values (cfg_values)
  );

  logic [PITCH_BITS-1:0]    previous_pitch;
  logic                     previous_was_note;
  logic [ID_BITS-1:0]       previous_id;
  logic [POSITION_BITS-1:0] previous_position;
  logic [POSITION_BITS-1:0] kept_count;
  logic                     run_direction_up;
  logic [FIELD_BITS-1:0]    run_steps;
  logic [POSITION_BITS-1:0] run_start_index;
  logic [ID_BITS-1:0]       run_start_ident;

  logic [PITCH_BITS-1:0]    previous_pitch_next;
  logic                     previous_was_note_next;
  logic [ID_BITS-1:0]       previous_id_next;
  logic [POSITION_BITS-1:0] previous_position_next;
  logic [POSITION_BITS-1:0] kept_count_next;
  logic                     run_direction_up_next;
  logic [FIELD_BITS-1:0]    run_steps_next;
  logic [POSITION_BITS-1:0] run_start_index_next;
  logic [ID_BITS-1:0]       run_start_ident_next;

  logic                     accept;
  logic                     kept;
  logic                     is_note;
  logic                     step_up;
  logic [PITCH_BITS-1:0]    step_mag;
  logic                     has_step;
  logic [FIELD_BITS-1:0]    old_len;
  logic                     old_report;
  logic [FIELD_BITS-1:0]    mid_len;
  logic                     mid_report;
  logic                     emit_old;
  logic                     emit_mid;
  logic                     emit;
  result_t                  result;

  result_t                  queue [2];
  logic                     wr_ptr;
  logic                     rd_ptr;
  logic [1:0]               queue_count;
  logic                     pop;

  assign is_note = (note_in.event_kind == KIND_NOTE_ON);
  assign kept    = is_note || (note_in.event_kind == KIND_REST_ON);
  assign step_up = note_in.note_pitch > previous_pitch;
  assign step_mag = step_up ? (note_in.note_pitch - previous_pitch)
                            : (previous_pitch - note_in.note_pitch);
  assign has_step = is_note && previous_was_note && (step_mag != '0) &&
                    (step_mag >= cfg_values.min_step) && (step_mag <= cfg_values.max_step);

  assign old_len    = (run_steps == STEPS_MAX) ? STEPS_MAX : run_steps + 1'b1;
  assign old_report = old_len >= FIELD_BITS'(cfg_values.min_run_notes);

  always_comb begin
    previous_pitch_next    = previous_pitch;
    previous_was_note_next = previous_was_note;
    previous_id_next       = previous_id;
    previous_position_next = previous_position;
    kept_count_next        = kept_count;
    run_direction_up_next  = run_direction_up;
    run_steps_next         = run_steps;
    run_start_index_next   = run_start_index;
    run_start_ident_next   = run_start_ident;
    emit_old               = 1'b0;
    if (kept) begin
      if (kept_count != POS_MAX) begin
        kept_count_next = kept_count + 1'b1;
      end
      if (has_step) begin
        if ((run_steps != '0) && (run_direction_up == step_up)) begin
          if (run_steps != STEPS_MAX) begin
            run_steps_next = run_steps + 1'b1;
          end
        end else begin
          emit_old             = (run_steps != '0) && old_report;
          run_start_index_next = previous_position;
          run_start_ident_next = previous_id;
          run_direction_up_next = step_up;
          run_steps_next       = FIELD_BITS'(1);
        end
      end else if (run_steps != '0) begin
        emit_old       = old_report;
        run_steps_next = '0;
      end
      previous_was_note_next = is_note;
      previous_pitch_next    = note_in.note_pitch;
      previous_id_next       = ID_BITS'(note_in.note_id);
      previous_position_next = kept_count;
    end
  end

  assign mid_len    = (run_steps_next == STEPS_MAX) ? STEPS_MAX : run_steps_next + 1'b1;
  assign mid_report = mid_len >= FIELD_BITS'(cfg_values.min_run_notes);
  assign emit_mid   = note_in.last && !emit_old && (run_steps_next != '0) && mid_report;
  assign emit       = emit_old || emit_mid;

  always_comb begin
    if (emit_old) begin
      result.start_position = FIELD_BITS'(run_start_index);
      result.first_note_id  = FIELD_BITS'(run_start_ident);
      result.run_length     = old_len;
      result.is_up          = run_direction_up;
    end else begin
      result.start_position = FIELD_BITS'(run_start_index_next);
      result.first_note_id  = FIELD_BITS'(run_start_ident_next);
      result.run_length     = mid_len;
      result.is_up          = run_direction_up_next;
    end
  end

  assign note_in.ready = (queue_count != 2'd2);
  assign accept        = note_in.valid && note_in.ready;
  assign pop           = run_out.valid && run_out.ready;

  assign run_out.valid          = (queue_count != 2'd0);
  assign run_out.start_position = queue[rd_ptr].start_position;
  assign run_out.first_note_id  = queue[rd_ptr].first_note_id;
  assign run_out.run_length     = queue[rd_ptr].run_length;
  assign run_out.is_up          = queue[rd_ptr].is_up;

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      queue[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pitch    <= '0;
      previous_was_note <= 1'b0;
      previous_id       <= '0;
      previous_position <= '0;
      kept_count        <= '0;
      run_direction_up  <= 1'b0;
      run_steps         <= '0;
      run_start_index   <= '0;
      run_start_ident   <= '0;
      wr_ptr            <= 1'b0;
      rd_ptr            <= 1'b0;
      queue_count       <= 2'd0;
    end else begin
      if (accept) begin
        previous_pitch   <= previous_pitch_next;
        previous_id      <= previous_id_next;
        run_direction_up <= run_direction_up_next;
        run_start_index  <= run_start_index_next;
        run_start_ident  <= run_start_ident_next;
        if (note_in.last) begin
          previous_was_note <= 1'b0;
          previous_position <= '0;
          kept_count        <= '0;
          run_steps         <= '0;
        end else begin
          previous_was_note <= previous_was_note_next;
          previous_position <= previous_position_next;
          kept_count        <= kept_count_next;
          run_steps         <= run_steps_next;
        end
      end
      if (accept && emit) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      queue_count <= queue_count + {1'b0, accept && emit} - {1'b0, pop};
    end
  end

endmodule

// File: hdl/mnrd_cfg_regs.sv
// Configuration registers of the monotonic note run detector.
module mnrd_cfg_regs import mnrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mnrd_cfg_if.sink   cfg,
  output cfg_t       cfg_values
);

  cfg_t regs;

  assign cfg.ready  = 1'b1;
  assign cfg_values = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_step      <= MIN_STEP_RESET;
      regs.max_step      <= MAX_STEP_RESET;
      regs.min_run_notes <= MIN_RUN_NOTES_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MIN_STEP:      regs.min_step      <= cfg.data[STEP_BITS-1:0];
        CFG_MAX_STEP:      regs.max_step      <= cfg.data[STEP_BITS-1:0];
        CFG_MIN_RUN_NOTES: regs.min_run_notes <= cfg.data[NOTES_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sim/monotonic_note_run_detector_unit_tb.sv
// Self-checking testbench of the monotonic note run detector, with its own run predictor.
module monotonic_note_run_detector_unit_tb;
  import mnrd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_PCT = 17;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 128;

  class note_run_tracker;
    logic [STEP_BITS-1:0] step_lo;
    logic [STEP_BITS-1:0] step_hi;
    logic [NOTES_BITS-1:0] report_len;
    logic [PITCH_BITS-1:0] last_pitch;
    bit last_was_note;
    logic [FIELD_BITS-1:0] last_ident;
    logic [FIELD_BITS-1:0] last_index;
    logic [FIELD_BITS-1:0] kept_total;
    bit open_up;
    logic [FIELD_BITS-1:0] open_steps;
    logic [FIELD_BITS-1:0] open_index;
    logic [FIELD_BITS-1:0] open_ident;
    result_t pending_runs[$];
    int errors;

    function new();
      step_lo = MIN_STEP_RESET;
      step_hi = MAX_STEP_RESET;
      report_len = MIN_RUN_NOTES_RESET;
      last_pitch = '0;
      last_was_note = 0;
      last_ident = '0;
      last_index = '0;
      kept_total = '0;
      open_up = 0;
      open_steps = '0;
      open_index = '0;
      open_ident = '0;
      errors = 0;
    endfunction

    function void set_config(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        CFG_MIN_STEP: step_lo = val[STEP_BITS-1:0];
        CFG_MAX_STEP: step_hi = val[STEP_BITS-1:0];
        CFG_MIN_RUN_NOTES: report_len = val;
        default: ;
      endcase
    endfunction

    function bit close_open_run(output result_t r);
      int len;
      len = open_steps + 1;
      if (len > 65535) len = 65535;
      r = '0;
      if (len < report_len) return 0;
      r.start_position = open_index;
      r.first_note_id = open_ident;
      r.run_length = len[FIELD_BITS-1:0];
      r.is_up = open_up;
      return 1;
    endfunction

    function void note_event(event_kind_t kind, logic [PITCH_BITS-1:0] pitch,
                             logic [FIELD_BITS-1:0] ident, bit is_last);
      bit got;
      bit has_step;
      bit up;
      int mag;
      logic [FIELD_BITS-1:0] pos;
      result_t r;
      got = 0;
      if (kind == KIND_NOTE_ON || kind == KIND_REST_ON) begin
        pos = kept_total;
        if (kept_total != '1) kept_total++;
        has_step = 0;
        up = 0;
        if (kind == KIND_NOTE_ON && last_was_note) begin
          up = pitch > last_pitch;
          mag = up ? pitch - last_pitch : last_pitch - pitch;
          has_step = mag != 0 && mag >= step_lo && mag <= step_hi;
        end
        if (has_step) begin
          if (open_steps != 0 && open_up == up) begin
            if (open_steps != '1) open_steps++;
          end else begin
            if (open_steps != 0) got = close_open_run(r);
            open_index = last_index;
            open_ident = last_ident;
            open_up = up;
            open_steps = 1;
          end
        end else if (open_steps != 0) begin
          got = close_open_run(r);
          open_steps = 0;
        end
        last_was_note = (kind == KIND_NOTE_ON);
        last_pitch = pitch;
        last_ident = ident;
        last_index = pos;
      end
      if (is_last) begin
        if (open_steps != 0 && !got) got = close_open_run(r);
        open_steps = 0;
        kept_total = 0;
        last_was_note = 0;
        last_index = 0;
      end
      if (got) pending_runs.insert(pending_runs.size(), r);
    endfunction

    function void check_run(result_t got);
      result_t want;
      if (pending_runs.size() == 0) begin
        $display("%0t: unexpected run result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_runs.pop_front();
      if (got.start_position != want.start_position ||
          got.first_note_id != want.first_note_id ||
          got.run_length != want.run_length || got.is_up != want.is_up) begin
        $display("%0t: run result mismatch, expected %p, actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  int cycles = 0;
  bit steady = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int cur_lo = MIN_STEP_RESET;
  int cur_hi = MAX_STEP_RESET;
  int gen_pitch = 60;
  bit gen_up = 1;
  note_run_tracker tracker = new();

  mnrd_note_if note_bus();
  mnrd_run_if run_bus();
  mnrd_cfg_if cfg_bus();

  monotonic_note_run_detector_unit dut (
    .clk(clk),
    .rst(rst),
    .note_in(note_bus),
    .run_out(run_bus),
    .cfg(cfg_bus)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("monotonic_note_run_detector_unit verification failed");
      $finish;
    end
  end

  initial begin
    run_bus.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        run_bus.ready <= 0;
      end else begin
        run_bus.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && run_bus.valid && run_bus.ready) begin
      got.start_position = run_bus.start_position;
      got.first_note_id = run_bus.first_note_id;
      got.run_length = run_bus.run_length;
      got.is_up = run_bus.is_up;
      tracker.check_run(got);
    end
  end

  task automatic send_event(event_kind_t kind, logic [PITCH_BITS-1:0] pitch,
                            logic [FIELD_BITS-1:0] ident, bit is_last);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      note_bus.valid <= 0;
      @(negedge clk);
    end
    note_bus.valid <= 1;
    note_bus.event_kind <= kind;
    note_bus.note_pitch <= pitch;
    note_bus.note_id <= ident;
    note_bus.last <= is_last;
    do @(posedge clk); while (!note_bus.ready);
    tracker.note_event(kind, pitch, ident, is_last);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    tracker.set_config(idx, val);
    @(negedge clk);
    cfg_bus.valid <= 0;
  endtask

  task automatic set_phase(int lo, int hi, int notes);
    write_reg(CFG_MIN_STEP, CFG_DATA_BITS'(lo));
    write_reg(CFG_MAX_STEP, CFG_DATA_BITS'(hi));
    write_reg(CFG_MIN_RUN_NOTES, CFG_DATA_BITS'(notes));
    cur_lo = lo;
    cur_hi = hi;
  endtask

  task automatic drain();
    @(negedge clk);
    note_bus.valid <= 0;
    while (tracker.pending_runs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random(bit allow_last);
    int r;
    int lo;
    int hi;
    int mag;
    int np;
    event_kind_t kind;
    logic [PITCH_BITS-1:0] pitch;
    r = $urandom_range(0, 99);
    if (r < 6) kind = KIND_REST_ON;
    else if (r < 10) kind = $urandom_range(0, 1) ? KIND_OTHER : KIND_SPARE;
    else kind = KIND_NOTE_ON;
    pitch = PITCH_BITS'($urandom_range(0, 127));
    if (kind == KIND_NOTE_ON && $urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 5) == 0) gen_up = !gen_up;
      lo = (cur_lo > 0) ? cur_lo - 1 : 0;
      hi = (cur_hi < 127) ? cur_hi + 1 : 127;
      mag = $urandom_range(hi, lo);
      np = gen_up ? gen_pitch + mag : gen_pitch - mag;
      if (np < 0 || np > 127) begin
        gen_up = !gen_up;
        np = gen_up ? gen_pitch + mag : gen_pitch - mag;
      end
      if (np < 0) np = 0;
      if (np > 127) np = 127;
      pitch = PITCH_BITS'(np);
    end
    if (kind == KIND_NOTE_ON) gen_pitch = pitch;
    send_event(kind, pitch, FIELD_BITS'($urandom_range(0, 65535)),
               allow_last && $urandom_range(0, 39) == 0);
  endtask

  initial begin
    int lo_set[8] = '{1, 0, 3, 127, 6, 0, 1, 2};
    int hi_set[8] = '{2, 127, 5, 127, 2, 0, 12, 4};
    int notes_set[8] = '{3, 2, 4, 255, 3, 2, 2, 8};
    rst = 1;
    note_bus.valid = 0;
    note_bus.event_kind = KIND_OTHER;
    note_bus.note_pitch = '0;
    note_bus.note_id = '0;
    note_bus.last = 0;
    cfg_bus.valid = 0;
    cfg_bus.index = CFG_MIN_STEP;
    cfg_bus.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    send_event(KIND_NOTE_ON, 60, 16'h0000, 0);
    send_event(KIND_NOTE_ON, 61, 16'h0001, 0);
    send_event(KIND_NOTE_ON, 63, 16'h0002, 0);
    send_event(KIND_NOTE_ON, 62, 16'h0003, 0);
    send_event(KIND_NOTE_ON, 62, 16'h0004, 0);
    send_event(KIND_REST_ON, 0, 16'h0005, 0);
    send_event(KIND_NOTE_ON, 0, 16'hFFFF, 0);
    send_event(KIND_NOTE_ON, 2, 16'h8000, 0);
    send_event(KIND_OTHER, 127, 16'h7FFF, 0);
    send_event(KIND_NOTE_ON, 4, 16'h00FF, 0);
    send_event(KIND_SPARE, 5, 16'hFF00, 1);
    send_event(KIND_NOTE_ON, 127, 16'hAAAA, 0);
    send_event(KIND_NOTE_ON, 125, 16'h5555, 0);
    send_event(KIND_NOTE_ON, 123, 16'h1234, 0);
    send_event(KIND_NOTE_ON, 125, 16'h4321, 1);
    send_event(KIND_NOTE_ON, 10, 16'h0010, 0);
    send_event(KIND_NOTE_ON, 11, 16'h0011, 0);
    send_event(KIND_NOTE_ON, 10, 16'h0012, 1);
    send_event(KIND_NOTE_ON, 50, 16'h0013, 0);
    send_event(KIND_NOTE_ON, 53, 16'h0014, 0);
    send_event(KIND_REST_ON, 127, 16'h0015, 1);
    drain();

    set_phase(0, 127, 2);
    send_event(KIND_NOTE_ON, 5, 16'h0100, 0);
    send_event(KIND_NOTE_ON, 5, 16'h0101, 0);
    send_event(KIND_NOTE_ON, 0, 16'h0102, 0);
    send_event(KIND_NOTE_ON, 127, 16'h0103, 0);
    send_event(KIND_NOTE_ON, 0, 16'h0104, 1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_phase(lo_set[ph], hi_set[ph], notes_set[ph]);
      steady = (ph == 6);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == 40) hold_req = 1;
        send_random(1);
      end
      drain();
    end
    steady = 0;

    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_runs.size() == 0) begin
      $display("monotonic_note_run_detector_unit verification clean");
    end else begin
      if (tracker.pending_runs.size() != 0)
        $display("%0t: %0d expected run results never arrived, expected %p, actual none",
                 $time, tracker.pending_runs.size(), tracker.pending_runs[0]);
      $display("monotonic_note_run_detector_unit verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mnrd_pkg.sv
hdl/mnrd_if.sv
hdl/mnrd_cfg_regs.sv
hdl/monotonic_note_run_detector_unit.sv
sim/monotonic_note_run_detector_unit_tb.sv
